/* rtl/cbwe_pkg.sv */
// ----------------------------------------------------------------------------
// cbwe_pkg
// Shared types, command codes, waveform tables and scaling constants of the
// cassette bit waveform encoder.
// ----------------------------------------------------------------------------
package cbwe_pkg;

  localparam int SAMPLES_EACH_BIT = 38;
  localparam int BITS_EACH_BYTE   = 8;
  localparam int IDX_W            = $clog2(SAMPLES_EACH_BIT);
  localparam int SLOTS            = 8;

  localparam logic [7:0] CENTER       = 8'd127;
  localparam logic [6:0] PERCENT_BASE = 7'd100;
  localparam logic [9:0] GAIN_RESET   = 10'd10;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 91180.
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // One audio sample moving between the sequencer, the scale unit and the packer.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] sample;
  } smp_t;

  localparam logic [7:0] WAVE_ONE [SAMPLES_EACH_BIT] = '{
    8'd156, 8'd178, 8'd189, 8'd191, 8'd195, 8'd179, 8'd118, 8'd88,  8'd75,  8'd70,
    8'd70,  8'd67,  8'd110, 8'd163, 8'd180, 8'd190, 8'd190, 8'd195, 8'd168, 8'd108,
    8'd84,  8'd73,  8'd69,  8'd69,  8'd68,  8'd117, 8'd165, 8'd181, 8'd190, 8'd190,
    8'd195, 8'd161, 8'd104, 8'd83,  8'd72,  8'd69,  8'd67,  8'd72
  };

  localparam logic [7:0] WAVE_ZERO [SAMPLES_EACH_BIT] = '{
    8'd165, 8'd181, 8'd190, 8'd190, 8'd195, 8'd161, 8'd104, 8'd83,  8'd72,  8'd69,
    8'd67,  8'd72,  8'd129, 8'd169, 8'd183, 8'd190, 8'd192, 8'd192, 8'd191, 8'd191,
    8'd189, 8'd189, 8'd186, 8'd189, 8'd157, 8'd98,  8'd76,  8'd65,  8'd62,  8'd61,
    8'd61,  8'd62,  8'd63,  8'd64,  8'd64,  8'd67,  8'd65,  8'd106
  };

  function automatic logic [7:0] wave_sample(input logic bit_val, input logic [IDX_W-1:0] idx);
    logic [7:0] s;
    if (bit_val) begin
      s = WAVE_ONE[idx];
    end else begin
      s = WAVE_ZERO[idx];
    end
    return s;
  endfunction

endpackage

/* rtl/cbwe_seq.sv */
// ----------------------------------------------------------------------------
// cbwe_seq
// Sample sequencer: walks the eight bits of a byte MSB first and the table
// index within each bit, issuing one table sample per advance.
// ----------------------------------------------------------------------------
module cbwe_seq
  import cbwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] start_byte,
  input  logic       adv,
  output logic       active,
  output smp_t       smp
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_EACH_BIT - 1);

  logic [7:0]       current_byte;
  logic [2:0]       bit_num;
  logic [IDX_W-1:0] idx;
  logic             bit_val;
  logic             at_end;

  assign bit_val    = current_byte[3'd7 - bit_num];
  assign at_end     = (bit_num == 3'd7) && (idx == IDX_LAST);
  assign smp.valid  = active;
  assign smp.last   = at_end;
  assign smp.sample = wave_sample(bit_val, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      current_byte <= 8'd0;
      bit_num      <= 3'd0;
      idx          <= '0;
    end else if (start) begin
      active       <= 1'b1;
      current_byte <= start_byte;
      bit_num      <= 3'd0;
      idx          <= '0;
    end else if (active && adv) begin
      if (idx == IDX_LAST) begin
        idx     <= '0;
        bit_num <= bit_num + 3'd1;
        if (at_end) begin
          active <= 1'b0;
        end
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

/* rtl/cbwe_scale.sv */
// ----------------------------------------------------------------------------
// cbwe_scale
// Shared three-stage scale unit: 127 + trunc((s - 127) * num / 100), clamped
// to 0..255. The division is a reciprocal multiply on the magnitude.
// ----------------------------------------------------------------------------
module cbwe_scale
  import cbwe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic signed [10:0] num,
  input  smp_t               smp_in,
  output smp_t               smp_out,
  output logic               busy
);

  // Stage 1: centered sample times the gain numerator.
  logic               v1, l1;
  logic signed [19:0] p1;
  // Stage 2: quotient magnitude and sign.
  logic               v2, l2, n2;
  logic [9:0]         q2;
  // Stage 3: final sample.
  logic               v3, l3;
  logic [7:0]         s3;

  logic signed [8:0]  c;
  logic signed [19:0] p1_next;
  logic [16:0]        mag;
  logic [33:0]        recip_prod;
  logic signed [11:0] v;
  logic [7:0]         s3_next;

  assign c       = $signed({1'b0, smp_in.sample}) - $signed({1'b0, CENTER});
  assign p1_next = $signed({{11{c[8]}}, c}) * $signed({{9{num[10]}}, num});

  // The magnitude stays below 128 * 612, so 17 bits hold it.
  assign mag        = p1[19] ? 17'(-p1) : 17'(p1);
  assign recip_prod = {17'd0, mag} * {17'd0, RECIP_100};

  assign v = n2 ? ($signed({4'd0, CENTER}) - $signed({2'd0, q2}))
                : ($signed({4'd0, CENTER}) + $signed({2'd0, q2}));

  always_comb begin
    if (v < 0) begin
      s3_next = 8'd0;
    end else if (v > 12'sd255) begin
      s3_next = 8'd255;
    end else begin
      s3_next = v[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= smp_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1 <= smp_in.last;
      p1 <= p1_next;
      l2 <= l1;
      n2 <= p1[19];
      q2 <= recip_prod[RECIP_SHIFT+9:RECIP_SHIFT];
      l3 <= l2;
      s3 <= s3_next;
    end
  end

  assign smp_out.valid  = v3;
  assign smp_out.last   = l3;
  assign smp_out.sample = s3;
  assign busy           = v1 | v2 | v3;

endmodule

/* rtl/cassette_bit_waveform_encoder.sv */
// ----------------------------------------------------------------------------
// cassette_bit_waveform_encoder
// An encode streams 304 samples, one a cycle while the output does not stall,
// through the shared scale unit, which is three stages deep. The next item is
// taken only once the sequencer, the scale unit and the pack buffer are empty,
// so output stalls delay it. A raw fill loads the pack buffer directly; the next
// item is taken once its word has moved to the output register. A clear only
// resets the running sum.
// Synchronous reset clears control state and the running sum; gain returns to 10.
// ----------------------------------------------------------------------------
module cassette_bit_waveform_encoder
  import cbwe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], data[9:2], add_to_sum[10], fill_count[14:11], zero[15]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sample_0[7:0] .. sample_7[63:56], valid_count[67:64], running_sum[83:68],
  // zero[87:84]
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [9:0]         gain;
  logic signed [10:0] num;
  logic [15:0]        byte_sum;

  cmd_t       in_cmd;
  logic [7:0] in_data;
  logic       in_add;
  logic [3:0] in_count;
  logic [3:0] raw_count;
  logic       in_fire;

  assign in_cmd   = cmd_t'(s_axis_tdata[1:0]);
  assign in_data  = s_axis_tdata[9:2];
  assign in_add   = s_axis_tdata[10];
  assign in_count = s_axis_tdata[14:11];
  assign raw_count = (in_count > 4'd8) ? 4'd8 : in_count;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // Pack buffer gathers eight encoded samples, or takes a raw fill at once, before they move to the output register.
  logic [7:0] pack [SLOTS];
  logic [2:0] pack_cnt;
  logic [3:0] pack_vc;
  logic       pack_last;
  logic       pack_full;

  logic [7:0]  out_smp [SLOTS];
  logic [3:0]  out_vc;
  logic [15:0] out_sum;

  logic out_load;
  logic adv;
  logic seq_active;
  logic scale_busy;
  smp_t seq_smp;
  smp_t scale_smp;

  assign out_load = pack_full && (!m_axis_tvalid || m_axis_tready);
  assign adv      = !pack_full || out_load;
  assign s_axis_tready = !seq_active && !scale_busy && !pack_full;

  cbwe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (in_fire && (in_cmd == CMD_ENCODE)),
    .start_byte (in_data),
    .adv        (adv),
    .active     (seq_active),
    .smp        (seq_smp)
  );

  cbwe_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .num     (num),
    .smp_in  (seq_smp),
    .smp_out (scale_smp),
    .busy    (scale_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_sum <= 16'd0;
    end else if (in_fire) begin
      unique case (in_cmd)
        CMD_ENCODE: begin
          if (in_add) begin
            byte_sum <= byte_sum + {8'd0, in_data};
          end
        end
        CMD_CLEAR: byte_sum <= 16'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_ENCODE)) begin
      num <= $signed({4'd0, PERCENT_BASE}) + $signed({gain[9], gain});
    end
  end

  // Pack control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_cnt  <= 3'd0;
      pack_full <= 1'b0;
    end else if (in_fire && (in_cmd == CMD_RAW) && (in_count != 4'd0)) begin
      pack_full <= 1'b1;
    end else if (adv && scale_smp.valid) begin
      pack_cnt  <= pack_cnt + 3'd1;
      pack_full <= (pack_cnt == 3'(SLOTS - 1));
    end else if (out_load) begin
      pack_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_RAW)) begin
      for (int j = 0; j < SLOTS; j++) begin
        pack[j] <= (4'(j) < raw_count) ? in_data : 8'd0;
      end
      pack_vc   <= raw_count;
      pack_last <= 1'b1;
    end else if (adv && scale_smp.valid) begin
      pack[pack_cnt] <= scale_smp.sample;
      pack_vc        <= 4'(SLOTS);
      pack_last      <= scale_smp.last;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_smp      <= pack;
      out_vc       <= pack_vc;
      out_sum      <= byte_sum;
      m_axis_tlast <= pack_last;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int j = 0; j < SLOTS; j++) begin
      m_axis_tdata[8*j +: 8] = out_smp[j];
    end
    m_axis_tdata[67:64] = out_vc;
    m_axis_tdata[83:68] = out_sum;
  end

  // No sample may be in flight while a new transaction can be taken.
  a_idle_when_ready : assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!scale_smp.valid && !seq_smp.valid))
    else $error("input ready while samples are in flight");

  // An accepted encode keeps the input side closed on the next cycle.
  a_encode_busy : assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_cmd == CMD_ENCODE)) |=> !s_axis_tready)
    else $error("encode did not start the sequencer");

  // Every delivered word carries between one and eight samples.
  a_valid_count : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_vc != 4'd0) && (out_vc <= 4'd8)))
    else $error("result word with bad sample count");

  // A full pack that cannot move freezes the scale pipeline.
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (pack_full && m_axis_tvalid && !m_axis_tready) |=> $stable(pack_cnt))
    else $error("pack buffer changed while stalled");

endmodule

/* test/tb_cassette_bit_waveform_encoder.sv */
// ----------------------------------------------------------------------------
// tb_cassette_bit_waveform_encoder
// Self-checking bench for the cassette bit waveform encoder. A queue-fed driver
// offers command items in random bursts. A monitor compares every result word
// with the words that a local model of the encoder computed when the item was
// taken. The run steps through several gain settings, the extremes among them,
// and the receiver stalls at random, with a few long hold-offs.
// ----------------------------------------------------------------------------
module tb_cassette_bit_waveform_encoder;
  import cbwe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS_EACH_BYTE = 38;
  localparam int MID_LEVEL       = 127;
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_CYCLES     = 1500;
  localparam int PHASES          = 8;
  localparam int ITEMS_EACH_PHASE = 47;

  localparam logic [7:0] MARK_WAVE [SAMPLES_EACH_BIT] = '{
    8'd156, 8'd178, 8'd189, 8'd191, 8'd195, 8'd179, 8'd118, 8'd88,  8'd75,  8'd70,
    8'd70,  8'd67,  8'd110, 8'd163, 8'd180, 8'd190, 8'd190, 8'd195, 8'd168, 8'd108,
    8'd84,  8'd73,  8'd69,  8'd69,  8'd68,  8'd117, 8'd165, 8'd181, 8'd190, 8'd190,
    8'd195, 8'd161, 8'd104, 8'd83,  8'd72,  8'd69,  8'd67,  8'd72
  };

  localparam logic [7:0] SPACE_WAVE [SAMPLES_EACH_BIT] = '{
    8'd165, 8'd181, 8'd190, 8'd190, 8'd195, 8'd161, 8'd104, 8'd83,  8'd72,  8'd69,
    8'd67,  8'd72,  8'd129, 8'd169, 8'd183, 8'd190, 8'd192, 8'd192, 8'd191, 8'd191,
    8'd189, 8'd189, 8'd186, 8'd189, 8'd157, 8'd98,  8'd76,  8'd65,  8'd62,  8'd61,
    8'd61,  8'd62,  8'd63,  8'd64,  8'd64,  8'd67,  8'd65,  8'd106
  };

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       add;
    logic [3:0] fill;
  } tape_item_t;

  typedef struct packed {
    logic [15:0]     sum;
    logic            last;
    logic [3:0]      count;
    logic [7:0][7:0] smp;
  } sample_word_t;

  typedef enum logic [1:0] {
    RX_FREE    = 2'd0,
    RX_BUSY    = 2'd1,
    RX_SLOW    = 2'd2,
    RX_PATTERN = 2'd3
  } rx_mode_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [9:0]  cfg_wr_data   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  cassette_bit_waveform_encoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model state.
  logic signed [9:0] gain_now = 10'sd10;
  logic [15:0]       byte_total = '0;

  tape_item_t   item_q[$];
  sample_word_t expected_words[$];

  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int words_seen   = 0;
  int errors       = 0;
  int n_encode     = 0;
  int n_raw        = 0;
  int n_clear      = 0;
  int n_ignored    = 0;
  int n_gains      = 1;
  int holds_done   = 0;

  task automatic report(input string what);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
  endtask

  function automatic logic [7:0] rescale(input logic [7:0] s);
    int num;
    int lvl;
    num = 100 + int'(gain_now);
    lvl = MID_LEVEL + ((int'(s) - MID_LEVEL) * num) / 100;
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    return lvl[7:0];
  endfunction

  // Works out the result words of one accepted item and queues them.
  task automatic predict_words(input tape_item_t it);
    sample_word_t w;
    int           pos;
    int           n;
    logic         b;
    case (it.cmd)
      CMD_ENCODE: begin
        n_encode++;
        if (it.add) byte_total = byte_total + 16'(it.data);
        for (int wi = 0; wi < WORDS_EACH_BYTE; wi++) begin
          w = '0;
          for (int j = 0; j < 8; j++) begin
            pos = wi * 8 + j;
            b = it.data[7 - pos / SAMPLES_EACH_BIT];
            w.smp[j] = rescale(b ? MARK_WAVE[pos % SAMPLES_EACH_BIT]
                                 : SPACE_WAVE[pos % SAMPLES_EACH_BIT]);
          end
          w.count = 4'd8;
          w.last  = (wi == WORDS_EACH_BYTE - 1);
          w.sum   = byte_total;
          expected_words.push_back(w);
        end
      end
      CMD_RAW: begin
        n_raw++;
        if (it.fill != 0) begin
          n = (it.fill > 8) ? 8 : int'(it.fill);
          w = '0;
          for (int j = 0; j < n; j++) w.smp[j] = it.data;
          w.count = 4'(n);
          w.last  = 1'b1;
          w.sum   = byte_total;
          expected_words.push_back(w);
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        byte_total = '0;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  // Driver: bursts of items with random gaps in between.
  tape_item_t cur_item;
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_words(cur_item);
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (item_q.size() != 0) begin
          cur_item = item_q.pop_front();
          s_axis_tdata  <= {1'b0, cur_item.fill, cur_item.add, cur_item.data, cur_item.cmd};
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 7))
              0, 1:    gap_left = 0;
              2, 3, 4: gap_left = $urandom_range(1, 10);
              5, 6:    gap_left = $urandom_range(1, 60);
              default: gap_left = $urandom_range(100, 350);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changing stall modes, plus long hold-offs that back the block up.
  rx_mode_t rx_mode   = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;
  int       hold_at   = 120;
  int       rx_tick   = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_left == 0 && words_seen >= hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_at   = hold_at + 2500;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 600);
        end else begin
          mode_left--;
        end
        rx_tick++;
        case (rx_mode)
          RX_FREE:    m_axis_tready <= 1'b1;
          RX_BUSY:    m_axis_tready <= ($urandom_range(0, 9) < 7);
          RX_SLOW:    m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:    m_axis_tready <= ((rx_tick % 7) < 3);
        endcase
      end
    end
  end

  // Monitor: every result transaction against the oldest expected word.
  always @(posedge clk) begin
    sample_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report($sformatf("result word with nothing expected, tdata %h", m_axis_tdata));
      end else begin
        want = expected_words.pop_front();
        for (int j = 0; j < 8; j++) begin
          if (m_axis_tdata[8*j +: 8] !== want.smp[j]) begin
            report($sformatf("word %0d sample_%0d got %0d want %0d", words_seen, j,
                             m_axis_tdata[8*j +: 8], want.smp[j]));
          end
        end
        if (m_axis_tdata[67:64] !== want.count) begin
          report($sformatf("word %0d valid_count got %0d want %0d", words_seen,
                           m_axis_tdata[67:64], want.count));
        end
        if (m_axis_tlast !== want.last) begin
          report($sformatf("word %0d last got %b want %b", words_seen, m_axis_tlast,
                           want.last));
        end
        if (m_axis_tdata[83:68] !== want.sum) begin
          report($sformatf("word %0d running_sum got %h want %h", words_seen,
                           m_axis_tdata[83:68], want.sum));
        end
      end
    end
  end

  task automatic queue_item(input cmd_t c, input logic [7:0] d, input logic a,
                            input logic [3:0] f);
    tape_item_t it;
    it.cmd  = c;
    it.data = d;
    it.add  = a;
    it.fill = f;
    item_q.push_back(it);
    pushed_cnt++;
  endtask

  function automatic tape_item_t random_item();
    tape_item_t it;
    int         pick;
    pick    = $urandom_range(0, 99);
    it.data = 8'($urandom_range(0, 255));
    it.add  = 1'($urandom_range(0, 1));
    it.fill = 4'($urandom_range(0, 15));
    if (pick < 58) begin
      it.cmd = CMD_ENCODE;
      // Mostly summed, often large bytes, so the upper sum bits move too.
      it.add = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 1) == 1) it.data[7:6] = 2'b11;
    end else if (pick < 93) begin
      it.cmd = CMD_RAW;
      if ($urandom_range(0, 4) != 0) it.fill = 4'($urandom_range(1, 8));
    end else if (pick < 95) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  // Waits until every item is taken and every word has come back, then lets
  // the block settle in case the last items produced no word.
  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_cnt != pushed_cnt || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gain(input int g);
    gain_now = 10'(g);
    n_gains++;
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 10'(g);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    tape_item_t it;
    int         counted;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset gain.
    queue_item(CMD_ENCODE, 8'h00, 1'b1, 4'd0);
    queue_item(CMD_ENCODE, 8'hFF, 1'b1, 4'd8);
    queue_item(CMD_ENCODE, 8'hA5, 1'b0, 4'd1);
    queue_item(CMD_ENCODE, 8'h5A, 1'b1, 4'd15);
    queue_item(CMD_RAW,    8'h00, 1'b0, 4'd1);
    queue_item(CMD_RAW,    8'hFF, 1'b0, 4'd8);
    queue_item(CMD_RAW,    8'h3C, 1'b0, 4'd9);
    queue_item(CMD_RAW,    8'hC3, 1'b1, 4'd15);
    queue_item(CMD_RAW,    8'h77, 1'b0, 4'd0);
    queue_item(CMD_RAW,    8'h81, 1'b1, 4'd5);
    queue_item(CMD_CLEAR,  8'hFF, 1'b1, 4'd15);
    queue_item(CMD_RAW,    8'h12, 1'b0, 4'd3);
    queue_item(CMD_NONE,   8'hEE, 1'b1, 4'd7);
    queue_item(CMD_ENCODE, 8'h01, 1'b1, 4'd2);
    queue_item(CMD_CLEAR,  8'h00, 1'b0, 4'd0);
    queue_item(CMD_ENCODE, 8'h80, 1'b1, 4'd4);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1:       set_gain(-90);
          2:       set_gain(300);
          3:       set_gain(-512);
          4:       set_gain(511);
          5:       set_gain(0);
          6:       set_gain(-100);
          default: set_gain($urandom_range(0, 1023));
        endcase
      end
      counted = 0;
      while (counted < ITEMS_EACH_PHASE) begin
        it = random_item();
        queue_item(it.cmd, it.data, it.add, it.fill);
        if (it.cmd != CMD_NONE) counted++;
      end
    end

    wait_drained();
    $display("Covered %0d encodes, %0d raw fills, %0d clears and %0d unused commands",
             n_encode, n_raw, n_clear, n_ignored);
    $display("under %0d gain settings; %0d words checked, %0d long receiver hold-offs.",
             n_gains, words_seen, holds_done);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d items taken and %0d words still expected.",
             accepted_cnt, expected_words.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
